@@ hdl/rbd_pkg.sv @@
`default_nettype none

package rbd_pkg;

    // Storage geometry.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the command and result items.
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POPPED_W = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                 cmd;
        logic [VALUE_W-1:0]   value;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [POPPED_W-1:0]  popped;
        logic [COUNT_W-1:0]   count;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

@@ hdl/rbd_ctrl.sv @@
`default_nettype none

module rbd_ctrl (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    output logic o_exec,
    output logic o_done
);

    rbd_pkg::t_state r_state;
    rbd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        o_exec  = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            rbd_pkg::S_IDLE: begin
                if (start) begin
                    o_exec  = 1'b1;
                    n_state = rbd_pkg::S_RESP;
                end
            end
            rbd_pkg::S_RESP: begin
                busy    = 1'b1;
                o_done  = 1'b1;
                n_state = rbd_pkg::S_IDLE;
            end
            default: begin
                n_state = rbd_pkg::S_IDLE;
            end
        endcase
    end

    // Every accepted command yields exactly one strobe, in the very next cycle.
    a_exec_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_exec |=> o_done)
        else $error("accepted command not followed by a result strobe");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_no_exec_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_exec)
        else $error("command executed while busy");

endmodule

`default_nettype wire

@@ hdl/rbd_dp.sv @@
`default_nettype none

module rbd_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_exec,
    input  rbd_pkg::t_in_item   i_item,
    output rbd_pkg::t_out_item  o_result
);

    localparam int DW   = rbd_pkg::DATA_WIDTH;
    localparam int IW   = rbd_pkg::IDX_W;
    localparam int CW   = rbd_pkg::CNT_W;
    localparam int PW   = rbd_pkg::POPPED_W;
    localparam int OCW  = rbd_pkg::COUNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(rbd_pkg::DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(rbd_pkg::DEPTH);

    logic [DW-1:0]     r_slots [rbd_pkg::DEPTH];
    logic [IW-1:0]     r_front;
    logic [IW-1:0]     r_back;
    logic [CW-1:0]     r_held;
    rbd_pkg::t_status  r_status;
    logic              r_pop_ok;
    logic [DW-1:0]     r_rd_data;

    logic [IW-1:0]     n_front;
    logic [IW-1:0]     n_back;
    logic [CW-1:0]     n_held;
    rbd_pkg::t_status  n_status;

    logic              is_push;
    logic              is_front;
    logic              full;
    logic              empty;
    logic              push_ok;
    logic              pop_ok;
    logic [IW-1:0]     front_dec;
    logic [IW-1:0]     front_inc;
    logic [IW-1:0]     back_dec;
    logic [IW-1:0]     back_inc;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     rd_addr;

    always_comb begin
        is_push  = (i_item.cmd == rbd_pkg::CMD_PUSH_FRONT) ||
                   (i_item.cmd == rbd_pkg::CMD_PUSH_BACK);
        is_front = (i_item.cmd == rbd_pkg::CMD_PUSH_FRONT) ||
                   (i_item.cmd == rbd_pkg::CMD_POP_FRONT);
        full     = (r_held == FULL_CNT);
        empty    = (r_held == '0);
        push_ok  = is_push && !full;
        pop_ok   = !is_push && !empty;

        front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
        front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
        back_dec  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;
        back_inc  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;

        wr_addr = is_front ? front_dec : back_inc;
        rd_addr = is_front ? r_front : r_back;

        n_front  = r_front;
        n_back   = r_back;
        n_held   = r_held;
        n_status = rbd_pkg::ST_OK;
        if (is_push) begin
            if (full) begin
                n_status = rbd_pkg::ST_FULL;
            end else begin
                n_held = r_held + 1'b1;
                if (is_front) begin
                    n_front = front_dec;
                end else begin
                    n_back = back_inc;
                end
            end
        end else begin
            if (empty) begin
                n_status = rbd_pkg::ST_EMPTY;
            end else begin
                n_held = r_held - 1'b1;
                if (is_front) begin
                    n_front = front_inc;
                end else begin
                    n_back = back_dec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= LAST_IDX;
            r_held  <= '0;
        end else if (i_exec) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            r_status <= n_status;
            r_pop_ok <= pop_ok;
        end
    end

    // Slot store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_exec && push_ok) begin
            r_slots[wr_addr] <= DW'(i_item.value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec && pop_ok) begin
            r_rd_data <= r_slots[rd_addr];
        end
    end

    always_comb begin
        o_result.status = r_status;
        o_result.popped = r_pop_ok ? PW'(r_rd_data) : '0;
        o_result.count  = OCW'(r_held);
    end

    a_held_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= FULL_CNT)
        else $error("element count exceeds capacity");

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && n_status != rbd_pkg::ST_OK) |=>
            ($stable(r_held) && $stable(r_front) && $stable(r_back)))
        else $error("rejected command changed the deque");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && pop_ok) |=> (r_held == $past(r_held) - 1'b1))
        else $error("successful pop did not decrement the count");

endmodule

`default_nettype wire

@@ hdl/ring_buffer_deque.sv @@
`default_nettype none

// Ring buffer deque: a double-ended queue of rbd_pkg::DEPTH elements kept in a
// circular slot store. A command is taken at a rising edge where start is high
// and busy is low; it pushes i_item.value at the front or the back, or pops one
// element from either end. Every command produces exactly one result, shown on
// o_result for a single cycle with o_done high, in the cycle right after the
// command is taken; the receiver cannot stall it, so it must capture the result
// on that strobe. busy is high during the result cycle, so no new command can be
// taken before the result has been shown. The result fields and the
// read port of the slot store are registered at the accepting edge.
// The gap between commands comes from the controller, which holds busy
// for the one cycle in which the result is shown. The result carries a status
// (ok, pop on empty, push on full dropped), the popped element (zero on pushes
// and failed pops) and the element count after the command. A rejected command
// leaves the deque untouched. No clearing pass follows reset: the store is only
// ever read at slots that an earlier push wrote.
module ring_buffer_deque (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  rbd_pkg::t_in_item   i_item,
    output logic                o_done,
    output rbd_pkg::t_out_item  o_result
);

    logic exec;

    // The controller sequences accept and result cycles.
    rbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_exec  (exec),
        .o_done  (o_done)
    );

    // The datapath holds the slots, both end indices and the count, and it
    // registers the result fields when a command executes.
    rbd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_exec   (exec),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
